[sv/sfec_pkg.sv]
// Shared types and constants for the spanning-forest edge classifier.
// No dependencies; imported by the sequencer, the top level and the checker.
package sfec_pkg;

	localparam int VERTEX_W = 10;
	localparam int COUNT_W  = 11;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 8;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAR,
		ST_GRD,
		ST_DONE
	} sfec_state_t;

	// result codes
	typedef enum logic [1:0] {
		STATUS_FOREST = 2'd0,
		STATUS_CYCLE  = 2'd1,
		STATUS_RANGE  = 2'd2
	} edge_status_t;

	// sequencer to output register
	typedef struct packed {
		logic         valid;
		edge_status_t status;
	} sfec_result_t;

endpackage

[sv/sfec_parent_ram.sv]
// Parent store of the union-find forest: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
module sfec_parent_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered: data follows in the next cycle
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/sfec_seq.sv]
// Sequencer: root finding with path halving, linking, range check and store clearing.
// Depends on sfec_pkg; drives the parent store ports.
module sfec_seq #(
	parameter int MAX_VERTICES = 1024,
	parameter int VW           = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sfec_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	input  logic [sfec_pkg::COUNT_W-1:0]   vertex_count,
	input  logic                           out_free,
	output sfec_pkg::sfec_result_t         res,
	output logic                           mem_we,
	output logic [VW-1:0]                  mem_waddr,
	output logic [VW-1:0]                  mem_wdata,
	output logic [VW-1:0]                  mem_raddr,
	input  logic [VW-1:0]                  mem_rdata
);

	import sfec_pkg::*;

	localparam int CW = VW + 1;

	sfec_state_t           state_q, state_d;
	logic [VW-1:0]         x_q, x_d, b_q, b_d, ra_q, ra_d;
	logic                  side_q, side_d, last_q, last_d;
	edge_status_t          status_q, status_d;
	logic [CW-1:0]         cnt_q, cnt_d, dirty_q, dirty_d;
	logic [VERTEX_W-1:0]   in_a, in_b;
	logic                  a_ok, b_ok;
	logic [CW-1:0]         wr_top;

	assign in_a = s_tdata[VERTEX_W-1:0];
	assign in_b = s_tdata[2*VERTEX_W-1:VERTEX_W];

	// range check against both the configured count and the store depth
	assign a_ok = ({1'b0, in_a} < vertex_count) && (32'(in_a) < 32'(MAX_VERTICES));
	assign b_ok = ({1'b0, in_b} < vertex_count) && (32'(in_b) < 32'(MAX_VERTICES));

	assign wr_top = {1'b0, mem_waddr} + CW'(1);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			side_q  <= 1'b0;
			last_q  <= 1'b0;
			cnt_q   <= '0;
			dirty_q <= CW'(MAX_VERTICES);
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			last_q  <= last_d;
			cnt_q   <= cnt_d;
			dirty_q <= dirty_d;
		end
	end

	// working values
	always_ff @(posedge clk) begin
		x_q      <= x_d;
		b_q      <= b_d;
		ra_q     <= ra_d;
		status_q <= status_d;
	end

	// next state and store accesses
	always_comb begin
		state_d    = state_q;
		x_d        = x_q;
		b_d        = b_q;
		ra_d       = ra_q;
		side_d     = side_q;
		last_d     = last_q;
		status_d   = status_q;
		cnt_d      = cnt_q;
		dirty_d    = dirty_q;
		mem_we     = 1'b0;
		mem_waddr  = x_q;
		mem_wdata  = mem_rdata;
		mem_raddr  = x_q;
		s_tready   = 1'b0;
		res.valid  = 1'b0;
		res.status = status_q;

		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == dirty_q) begin
					dirty_d = '0;
					state_d = ST_IDLE;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q[VW-1:0];
					mem_wdata = cnt_q[VW-1:0];
					cnt_d     = cnt_q + CW'(1);
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					last_d = s_tlast;
					if (!(a_ok && b_ok)) begin
						status_d = STATUS_RANGE;
						state_d  = ST_DONE;
					end else begin
						x_d       = VW'(in_a);
						b_d       = VW'(in_b);
						side_d    = 1'b0;
						mem_raddr = VW'(in_a);
						state_d   = ST_PAR;
					end
				end
			end
			ST_PAR: begin
				if (mem_rdata == x_q) begin
					// x is a root
					if (!side_q) begin
						ra_d      = x_q;
						x_d       = b_q;
						side_d    = 1'b1;
						mem_raddr = b_q;
					end else begin
						if (ra_q != x_q) begin
							mem_we    = 1'b1;
							mem_waddr = ra_q;
							mem_wdata = x_q;
							status_d  = STATUS_FOREST;
						end else begin
							status_d  = STATUS_CYCLE;
						end
						state_d = ST_DONE;
					end
				end else begin
					// fetch the grandparent
					mem_raddr = mem_rdata;
					state_d   = ST_GRD;
				end
			end
			ST_GRD: begin
				// halve the path: x points at its grandparent, then step there
				mem_we    = 1'b1;
				mem_waddr = x_q;
				mem_wdata = mem_rdata;
				x_d       = mem_rdata;
				mem_raddr = mem_rdata;
				state_d   = ST_PAR;
			end
			ST_DONE: begin
				if (out_free) begin
					res.valid = 1'b1;
					if (last_q) begin
						cnt_d   = '0;
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// high-water mark of written entries, bounds the next clear
		if (mem_we && (state_q != ST_CLEAR) && (wr_top > dirty_q)) begin
			dirty_d = wr_top;
		end
	end

endmodule

[sv/spanning_forest_edge_classifier_unit.sv]
// Top level: count register, result register, sequencer and parent store.
// Depends on sfec_pkg, sfec_seq and sfec_parent_ram.
// Each edge finds the root of vertex_a, then of vertex_b, halving paths through the one read
// port of the parent store; out-of-range edges skip the store. A new edge is taken only once
// the last result is in the result register. After a last edge the store is cleared, one entry
// per cycle up to the highest entry written; after reset the whole store is cleared before s_tready.
module spanning_forest_edge_classifier_unit #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sfec_pkg::S_DATA_W-1:0]  s_tdata,    // vertex_a[9:0], vertex_b[19:10]
	input  logic                           s_tlast,    // last_edge
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sfec_pkg::M_DATA_W-1:0]  m_tdata,    // edge_status[1:0]
	input  logic                           cfg_we,
	input  logic [sfec_pkg::COUNT_W-1:0]   cfg_wdata   // vertex_count
);

	import sfec_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);

	logic [COUNT_W-1:0] vertex_count_q;
	logic               m_valid_q;
	edge_status_t       m_status_q;
	logic               out_free;
	sfec_result_t       res;
	logic               mem_we;
	logic [VW-1:0]      mem_waddr, mem_wdata, mem_raddr, mem_rdata;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	assign out_free = !m_valid_q || m_tready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			m_status_q <= res.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'(m_status_q);

	sfec_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.VW           (VW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.vertex_count (vertex_count_q),
		.out_free     (out_free),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	sfec_parent_ram #(
		.DEPTH (MAX_VERTICES),
		.AW    (VW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[sv/sfec_checker.sv]
// Port-level checks for the spanning-forest edge classifier, bound to the top level.
// Depends on sfec_pkg widths only.
module sfec_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [sfec_pkg::M_DATA_W-1:0]  m_tdata
);

	import sfec_pkg::*;

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no result without an outstanding request
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without request");

	// one request at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request taken while busy");

	// only defined codes leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[M_DATA_W-1:2] == '0)
		else $error("undefined status code");

endmodule

bind spanning_forest_edge_classifier_unit sfec_checker u_sfec_checker (.*);
